@@ rtl/sdi12_pkg.sv @@
// ----------------------------------------------------------------------------
// sdi12_pkg
// types, register codes and frame builder for the sdi-12 line transceiver
// ----------------------------------------------------------------------------
package sdi12_pkg;

  localparam int TICK_W     = 20;
  localparam int BIT_TICK_W = 16;
  localparam int CHAR_W     = 7;
  localparam int FRAME_W    = 10;
  localparam int BIDX_W     = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_BREAK = 2'd2;
  localparam logic [1:0] OP_RECV  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_TICKS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_TICKS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_TICKS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARS   = 4'd3;

  localparam logic [BIT_TICK_W-1:0] BIT_TICKS_RST   = 16'd770;
  localparam logic [TICK_W-1:0]     BREAK_TICKS_RST = 20'd13000;
  localparam logic [TICK_W-1:0]     MARK_TICKS_RST  = 20'd9000;
  localparam logic [CHAR_W-1:0]     MAX_CHARS_RST   = 7'd31;

  localparam logic [CHAR_W-1:0] CHAR_CR    = 7'd13;
  localparam logic [BIDX_W-1:0] BIDX_LAST  = 4'd6;
  localparam logic [BIDX_W-1:0] BIDX_DATA  = 4'd7;
  localparam logic [BIDX_W-1:0] BIDX_STOP  = 4'd8;
  localparam logic [BIDX_W-1:0] BIDX_FRAME = 4'd10;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BRK_HI,
    PH_BRK_LO,
    PH_TX,
    PH_RX_WAIT,
    PH_RX_START,
    PH_RX_DATA
  } phase_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CHAR_W-1:0] tx_char;
    logic              line_in;
  } in_item_t;

  typedef struct packed {
    logic              line_out;
    logic              drive_enable;
    logic              rx_valid;
    logic [CHAR_W-1:0] rx_char;
    logic              rx_end;
    logic              busy_res;
    logic              rejected;
  } out_item_t;

  typedef struct packed {
    logic [BIT_TICK_W-1:0] bit_ticks;
    logic [TICK_W-1:0]     break_ticks;
    logic [TICK_W-1:0]     mark_ticks;
    logic [CHAR_W-1:0]     max_chars;
  } cfg_regs_t;

  // start high, inverted data lsb first, parity over inverted data, stop low
  function automatic logic [FRAME_W-1:0] make_frame(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] inv;
    inv = ~c;
    return {1'b0, ^inv, inv, 1'b1};
  endfunction

endpackage

@@ rtl/sdi12_line_transceiver.sv @@
// ----------------------------------------------------------------------------
// sdi12_line_transceiver
// path: an accepted beat passes through the input register, then the result register
// throughput: one tick beat per cycle while out_ready does not stall the
//   result register, set by the single-pass step from input to result register
// reset: synchronous active-low rst_n returns the line to idle, clears all
//   counters and loads the default bit, break, mark and character limits
// ----------------------------------------------------------------------------
module sdi12_line_transceiver import sdi12_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t cfg_r;
  in_item_t  in_data_r;
  logic      in_valid_r;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t step_res;
  logic      advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_ticks   <= BIT_TICKS_RST;
      cfg_r.break_ticks <= BREAK_TICKS_RST;
      cfg_r.mark_ticks  <= MARK_TICKS_RST;
      cfg_r.max_chars   <= MAX_CHARS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BIT_TICKS:   cfg_r.bit_ticks   <= cfg_data[BIT_TICK_W-1:0];
        REG_BREAK_TICKS: cfg_r.break_ticks <= cfg_data[TICK_W-1:0];
        REG_MARK_TICKS:  cfg_r.mark_ticks  <= cfg_data[TICK_W-1:0];
        REG_MAX_CHARS:   cfg_r.max_chars   <= cfg_data[CHAR_W-1:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= step_res;
    end
  end

  sdi12_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .cfg     (cfg_r),
    .item    (in_data_r),
    .res     (step_res)
  );

  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.rejected |-> out_data_r.busy_res)
    else $error("rejected beat without busy");

  a_rx_not_driving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.rx_valid |-> !out_data_r.drive_enable)
    else $error("character received while driving");

  a_line_driven: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.line_out |-> out_data_r.drive_enable)
    else $error("line high while not driving");

  a_cr_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.rx_end && !out_data_r.rx_valid |-> out_data_r.rx_char == '0)
    else $error("end without character carries data");

endmodule

@@ rtl/sdi12_engine.sv @@
// ----------------------------------------------------------------------------
// sdi12_engine
// per-tick line state machine: break, frame transmit and character receive
// ----------------------------------------------------------------------------
module sdi12_engine import sdi12_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  cfg_regs_t cfg,
  input  in_item_t  item,
  output out_item_t res
);

  phase_t              phase_r, phase_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [BIDX_W-1:0]   bidx_r, bidx_nxt;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic [CHAR_W-1:0]   shift_r, shift_nxt;
  logic [CHAR_W-1:0]   count_r, count_nxt;
  logic [CHAR_W-1:0]   pend_r, pend_nxt;

  phase_t              ph_a;
  logic [TICK_W-1:0]   tick_a;
  logic [BIDX_W-1:0]   bidx_a;
  logic [FRAME_W-1:0]  frame_a;
  logic [CHAR_W-1:0]   shift_a;
  logic [CHAR_W-1:0]   count_a;
  logic [CHAR_W-1:0]   pend_a;
  logic                rej;

  logic [TICK_W-1:0]   tick_inc;
  logic [TICK_W-1:0]   target;
  logic [BIT_TICK_W:0] half_target;
  logic                done;
  logic [CHAR_W-1:0]   shift_smp;
  logic [CHAR_W-1:0]   count_inc;
  logic                cr_hit;
  logic                lim_hit;
  logic                rx_event;

  // request handling ahead of the phase step
  always_comb begin
    ph_a    = phase_r;
    tick_a  = tick_r;
    bidx_a  = bidx_r;
    frame_a = frame_r;
    shift_a = shift_r;
    count_a = count_r;
    pend_a  = pend_r;
    rej     = 1'b0;
    if (item.operation != OP_TICK) begin
      if (phase_r != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        case (item.operation)
          OP_SEND: begin
            frame_a = make_frame(item.tx_char);
            bidx_a  = '0;
            tick_a  = '0;
            ph_a    = PH_TX;
          end
          OP_BREAK: begin
            pend_a = item.tx_char;
            tick_a = '0;
            ph_a   = PH_BRK_HI;
          end
          OP_RECV: begin
            count_a = '0;
            shift_a = '0;
            bidx_a  = '0;
            tick_a  = '0;
            ph_a    = PH_RX_WAIT;
          end
          default: begin
            ph_a = phase_r;
          end
        endcase
      end
    end
  end

  assign half_target = {1'b0, cfg.bit_ticks} + {2'b00, cfg.bit_ticks[BIT_TICK_W-1:1]};

  always_comb begin
    case (ph_a)
      PH_BRK_HI:   target = cfg.break_ticks;
      PH_BRK_LO:   target = cfg.mark_ticks;
      PH_RX_START: target = TICK_W'(half_target);
      default:     target = TICK_W'(cfg.bit_ticks);
    endcase
  end

  assign tick_inc  = tick_a + 1'b1;
  assign done      = (tick_inc >= target);
  assign shift_smp = (bidx_a < BIDX_DATA) ? {~item.line_in, shift_a[CHAR_W-1:1]} : shift_a;
  assign count_inc = count_a + 1'b1;
  assign cr_hit    = (shift_smp == CHAR_CR);
  assign lim_hit   = (count_inc >= cfg.max_chars);
  assign rx_event  = done && (bidx_a == BIDX_LAST);

  // next state
  always_comb begin
    phase_nxt = ph_a;
    tick_nxt  = tick_a;
    bidx_nxt  = bidx_a;
    frame_nxt = frame_a;
    shift_nxt = shift_a;
    count_nxt = count_a;
    pend_nxt  = pend_a;
    case (ph_a)
      PH_BRK_HI: begin
        tick_nxt = done ? '0 : tick_inc;
        if (done) begin
          phase_nxt = PH_BRK_LO;
        end
      end
      PH_BRK_LO: begin
        tick_nxt = done ? '0 : tick_inc;
        if (done) begin
          frame_nxt = make_frame(pend_a);
          bidx_nxt  = '0;
          phase_nxt = PH_TX;
        end
      end
      PH_TX: begin
        tick_nxt = done ? '0 : tick_inc;
        if (done) begin
          if (bidx_a + 1'b1 >= BIDX_FRAME) begin
            bidx_nxt  = '0;
            phase_nxt = PH_IDLE;
          end else begin
            bidx_nxt = bidx_a + 1'b1;
          end
        end
      end
      PH_RX_WAIT: begin
        if (item.line_in) begin
          tick_nxt  = '0;
          bidx_nxt  = '0;
          phase_nxt = PH_RX_START;
        end
      end
      PH_RX_START, PH_RX_DATA: begin
        tick_nxt = done ? '0 : tick_inc;
        if (done) begin
          phase_nxt = PH_RX_DATA;
          shift_nxt = shift_smp;
          if (bidx_a == BIDX_LAST) begin
            if (cr_hit) begin
              phase_nxt = PH_IDLE;
              bidx_nxt  = '0;
            end else begin
              count_nxt = count_inc;
              if (lim_hit) begin
                phase_nxt = PH_IDLE;
                bidx_nxt  = '0;
              end else begin
                bidx_nxt = BIDX_DATA;
              end
            end
          end else if (bidx_a >= BIDX_STOP) begin
            bidx_nxt  = '0;
            phase_nxt = PH_RX_WAIT;
          end else begin
            bidx_nxt = bidx_a + 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // result
  always_comb begin
    res              = '0;
    res.rejected     = rej;
    res.busy_res     = (ph_a != PH_IDLE);
    case (ph_a)
      PH_BRK_HI: begin
        res.line_out     = 1'b1;
        res.drive_enable = 1'b1;
      end
      PH_BRK_LO: begin
        res.drive_enable = 1'b1;
      end
      PH_TX: begin
        res.line_out     = (bidx_a < BIDX_FRAME) ? frame_a[bidx_a] : 1'b0;
        res.drive_enable = 1'b1;
      end
      PH_RX_START, PH_RX_DATA: begin
        if (rx_event) begin
          if (cr_hit) begin
            res.rx_end = 1'b1;
          end else begin
            res.rx_valid = 1'b1;
            res.rx_char  = shift_smp;
            res.rx_end   = lim_hit;
          end
        end
      end
      default: begin
        res.line_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bidx_r  <= '0;
      frame_r <= '0;
      shift_r <= '0;
      count_r <= '0;
      pend_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bidx_r  <= bidx_nxt;
      frame_r <= frame_nxt;
      shift_r <= shift_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule
